// ===== rtl/vtt_pkg.sv =====
package vtt_pkg;

    localparam int LOST_LIMIT = 20;
    localparam int MISS_W = $clog2(LOST_LIMIT + 2);
    localparam logic [MISS_W-1:0] MISS_MAX = MISS_W'(LOST_LIMIT + 1);
    localparam logic [MISS_W-1:0] MISS_LIMIT = MISS_W'(LOST_LIMIT);

    localparam int CFG_W = 16;

    typedef enum logic [2:0] {
        REG_GAIN_X,
        REG_GAIN_Y,
        REG_MAX_VEL_X,
        REG_MAX_VEL_Y,
        REG_DEADBAND,
        REG_FWD_OFFSET,
        REG_DIST_THR,
        REG_TRACK_FWD
    } cfg_idx_t;

    localparam logic       CMD_VISION = 1'b0;
    localparam logic       CMD_TICK   = 1'b1;
    localparam logic [1:0] DET_LOST   = 2'd0;
    localparam logic [1:0] DET_SEEN   = 2'd1;
    localparam logic       ACT_HOLD   = 1'b0;
    localparam logic       ACT_MOVE   = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic [1:0]         detect_code;
    } in_t;

    typedef struct packed {
        logic               action;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic [15:0]        sequence_res;
    } out_t;

    typedef struct packed {
        logic [15:0]        gain_x;
        logic [15:0]        gain_y;
        logic [14:0]        max_vel_x;
        logic [14:0]        max_vel_y;
        logic [14:0]        deadband;
        logic signed [15:0] forward_offset;
        logic [14:0]        distance_threshold;
        logic               track_forward;
    } cfg_t;

    typedef struct packed {
        logic               detected;
        logic signed [16:0] ex;
        logic signed [15:0] ey;
    } tick_t;

endpackage

// ===== rtl/vtt_cfg.sv =====
module vtt_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  vtt_pkg::cfg_idx_t           cfg_index,
    input  logic [vtt_pkg::CFG_W-1:0]   cfg_data,
    output vtt_pkg::cfg_t               cfg
);

    vtt_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_x             <= 16'd256;
            cfg_reg.gain_y             <= 16'd256;
            cfg_reg.max_vel_x          <= 15'd128;
            cfg_reg.max_vel_y          <= 15'd128;
            cfg_reg.deadband           <= 15'd5;
            cfg_reg.forward_offset     <= 16'sd384;
            cfg_reg.distance_threshold <= 15'd51;
            cfg_reg.track_forward      <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                vtt_pkg::REG_GAIN_X:     cfg_reg.gain_x             <= cfg_data;
                vtt_pkg::REG_GAIN_Y:     cfg_reg.gain_y             <= cfg_data;
                vtt_pkg::REG_MAX_VEL_X:  cfg_reg.max_vel_x          <= cfg_data[14:0];
                vtt_pkg::REG_MAX_VEL_Y:  cfg_reg.max_vel_y          <= cfg_data[14:0];
                vtt_pkg::REG_DEADBAND:   cfg_reg.deadband           <= cfg_data[14:0];
                vtt_pkg::REG_FWD_OFFSET: cfg_reg.forward_offset     <= $signed(cfg_data);
                vtt_pkg::REG_DIST_THR:   cfg_reg.distance_threshold <= cfg_data[14:0];
                vtt_pkg::REG_TRACK_FWD:  cfg_reg.track_forward      <= cfg_data[0];
                default:                 cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/vtt_track.sv =====
module vtt_track (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  vtt_pkg::in_t    req_item,
    input  vtt_pkg::cfg_t   cfg,
    input  logic            law_ready,
    output logic            tick_valid,
    output vtt_pkg::tick_t  tick
);

    logic signed [15:0]          last_x_reg, last_x_next;
    logic signed [15:0]          last_y_reg, last_y_next;
    logic                        detected_reg, detected_next;
    logic [vtt_pkg::MISS_W-1:0]  miss_reg, miss_next;
    logic                        s1_vld_reg, s1_vld_next;
    vtt_pkg::tick_t              tick_reg, tick_next;
    logic                        accept;
    logic                        is_tick;

    assign req_stall = s1_vld_reg && !law_ready;
    assign accept    = req_valid && !req_stall;
    assign is_tick   = (req_item.command == vtt_pkg::CMD_TICK);

    // vision updates land in state at once, ticks take a snapshot of it
    always_comb
    begin
        last_x_next   = last_x_reg;
        last_y_next   = last_y_reg;
        detected_next = detected_reg;
        miss_next     = miss_reg;
        if (accept && !is_tick)
        begin
            last_x_next = req_item.target_x;
            last_y_next = req_item.target_y;
            case (req_item.detect_code)
                vtt_pkg::DET_LOST:
                begin
                    if (miss_reg < vtt_pkg::MISS_MAX)
                    begin
                        miss_next = miss_reg + 1'b1;
                    end
                end
                vtt_pkg::DET_SEEN:
                begin
                    detected_next = 1'b1;
                    miss_next     = '0;
                end
                default:
                begin
                    miss_next = miss_reg;
                end
            endcase
            if (miss_next > vtt_pkg::MISS_LIMIT)
            begin
                detected_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        tick_next.detected = detected_reg;
        tick_next.ex = cfg.track_forward
            ? 17'({last_x_reg[15], last_x_reg} - {cfg.forward_offset[15], cfg.forward_offset})
            : 17'sd0;
        tick_next.ey = last_y_reg;

        if (accept && is_tick)
        begin
            s1_vld_next = 1'b1;
        end
        else if (law_ready)
        begin
            s1_vld_next = 1'b0;
        end
        else
        begin
            s1_vld_next = s1_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            detected_reg <= 1'b0;
            miss_reg     <= '0;
            s1_vld_reg   <= 1'b0;
        end
        else
        begin
            last_x_reg   <= last_x_next;
            last_y_reg   <= last_y_next;
            detected_reg <= detected_next;
            miss_reg     <= miss_next;
            s1_vld_reg   <= s1_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_tick)
        begin
            tick_reg <= tick_next;
        end
    end

    assign tick_valid = s1_vld_reg;
    assign tick       = tick_reg;

endmodule

// ===== rtl/vtt_law.sv =====
module vtt_law (
    input  logic            clk,
    input  logic            rst_n,
    input  vtt_pkg::cfg_t   cfg,
    input  logic            tick_valid,
    input  vtt_pkg::tick_t  tick,
    output logic            law_ready,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output vtt_pkg::out_t   rsp_item
);

    logic [16:0]        mag_x, mag_y;
    logic               neg_x, neg_y;
    logic [33:0]        sq_x, sq_y;
    logic [34:0]        d2;
    logic [29:0]        t2;
    logic [32:0]        prod_x, prod_y;
    logic [33:0]        rnd_x, rnd_y;
    logic [25:0]        raw_x, raw_y;
    logic [14:0]        vm_x, vm_y;
    logic signed [15:0] vx, vy;
    logic               move;
    logic               load;
    logic               out_vld_reg;
    logic [15:0]        seq_reg, seq_next;
    vtt_pkg::out_t      out_reg, out_next;

    assign neg_x = tick.ex[16];
    assign neg_y = tick.ey[15];
    assign mag_x = neg_x ? 17'(-tick.ex) : 17'(tick.ex);
    assign mag_y = neg_y ? 17'(17'sd0 - {tick.ey[15], tick.ey}) : {1'b0, tick.ey};

    // distance test on squares
    assign sq_x = mag_x * mag_x;
    assign sq_y = mag_y * mag_y;
    assign d2   = {1'b0, sq_x} + {1'b0, sq_y};
    assign t2   = cfg.distance_threshold * cfg.distance_threshold;
    assign move = tick.detected && (d2 >= {5'd0, t2});

    // gain, round half away from zero on the magnitude
    assign prod_x = cfg.gain_x * mag_x;
    assign prod_y = cfg.gain_y * mag_y;
    assign rnd_x  = {1'b0, prod_x} + 34'd128;
    assign rnd_y  = {1'b0, prod_y} + 34'd128;
    assign raw_x  = rnd_x[33:8];
    assign raw_y  = rnd_y[33:8];

    // deadband before clamp
    always_comb
    begin
        if (raw_x < {11'd0, cfg.deadband})
        begin
            vm_x = '0;
        end
        else if (raw_x > {11'd0, cfg.max_vel_x})
        begin
            vm_x = cfg.max_vel_x;
        end
        else
        begin
            vm_x = raw_x[14:0];
        end

        if (raw_y < {11'd0, cfg.deadband})
        begin
            vm_y = '0;
        end
        else if (raw_y > {11'd0, cfg.max_vel_y})
        begin
            vm_y = cfg.max_vel_y;
        end
        else
        begin
            vm_y = raw_y[14:0];
        end
    end

    assign vx = neg_x ? $signed(16'd0 - {1'b0, vm_x}) : $signed({1'b0, vm_x});
    assign vy = neg_y ? $signed(16'd0 - {1'b0, vm_y}) : $signed({1'b0, vm_y});

    assign law_ready = !out_vld_reg || !rsp_stall;
    assign load      = tick_valid && law_ready;

    always_comb
    begin
        out_next.sequence_res = seq_reg;
        seq_next              = seq_reg;
        if (move)
        begin
            seq_next = seq_reg + 16'd1;
        end
        if (move && (vx != 16'sd0 || vy != 16'sd0))
        begin
            out_next.action = vtt_pkg::ACT_MOVE;
            out_next.vel_x  = vx;
            out_next.vel_y  = vy;
        end
        else
        begin
            out_next.action = vtt_pkg::ACT_HOLD;
            out_next.vel_x  = 16'sd0;
            out_next.vel_y  = 16'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            seq_reg     <= '0;
        end
        else
        begin
            if (load)
            begin
                out_vld_reg <= 1'b1;
                seq_reg     <= seq_next;
            end
            else if (!rsp_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_vld_reg;
    assign rsp_item  = out_reg;

endmodule

// ===== rtl/visual_target_tracking_velocity.sv =====
// a control tick's result passes through the track stage register, then the output register
// throughput: one item per cycle while the input is not stalled, vision updates and ticks alike
// vision updates give no result and update the target state in the accept cycle
// the input stalls only while a tick waits behind a result item not yet taken
// reset restores register defaults and clears target state and sequence number
module visual_target_tracking_velocity (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  vtt_pkg::in_t                req_item,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output vtt_pkg::out_t               rsp_item,
    input  logic                        cfg_wr_en,
    input  vtt_pkg::cfg_idx_t           cfg_index,
    input  logic [vtt_pkg::CFG_W-1:0]   cfg_data
);

    vtt_pkg::cfg_t  cfg;
    vtt_pkg::tick_t tick;
    logic           tick_valid;
    logic           law_ready;

    vtt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vtt_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_item   (req_item),
        .cfg        (cfg),
        .law_ready  (law_ready),
        .tick_valid (tick_valid),
        .tick       (tick)
    );

    vtt_law u_law (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .tick_valid (tick_valid),
        .tick       (tick),
        .law_ready  (law_ready),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_item   (rsp_item)
    );

endmodule

// ===== rtl/vtt_checker.sv =====
module vtt_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_stall,
    input  logic                        rsp_valid,
    input  logic                        rsp_stall,
    input  vtt_pkg::out_t               rsp_item
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
        else $error("result item changed while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("input stalled without a blocked result");

    a_hold_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.action == vtt_pkg::ACT_HOLD
            |-> rsp_item.vel_x == 16'sd0 && rsp_item.vel_y == 16'sd0)
        else $error("hold item with nonzero velocity");

    a_move_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.action == vtt_pkg::ACT_MOVE
            |-> rsp_item.vel_x != 16'sd0 || rsp_item.vel_y != 16'sd0)
        else $error("move item with zero velocity");

endmodule

bind visual_target_tracking_velocity vtt_checker u_vtt_checker (.*);

// ===== tb/visual_target_tracking_velocity_test.sv =====
`timescale 1ns / 100ps

module visual_target_tracking_velocity_test;

    localparam logic [1:0] DET_KEEP = 2'd2;
    localparam logic [1:0] DET_ODD  = 2'd3;
    localparam int SCRIPT_LEN = 25;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 50;
    localparam int LONG_HOLD = 150;

    typedef struct packed {
        logic               is_reg;
        vtt_pkg::cfg_idx_t  idx;
        logic [15:0]        data;
        vtt_pkg::in_t       it;
        logic               typed;
        vtt_pkg::out_t      want;
    } step_t;

    logic                       clk;
    logic                       rst_n;
    logic                       req_valid;
    logic                       req_stall;
    vtt_pkg::in_t               req_item;
    logic                       rsp_valid;
    logic                       rsp_stall;
    vtt_pkg::out_t              rsp_item;
    logic                       cfg_wr_en;
    vtt_pkg::cfg_idx_t          cfg_index;
    logic [vtt_pkg::CFG_W-1:0]  cfg_data;

    vtt_pkg::cfg_t      regs;
    logic signed [15:0] tgt_x;
    logic signed [15:0] tgt_y;
    bit                 tgt_seen;
    int                 miss_run;
    logic [15:0]        seq_no;

    vtt_pkg::out_t  due_cmds[$];
    int             bad_count;
    bit             tx_calm;
    bit             rx_calm;
    bit             long_hold_due;
    step_t          script [SCRIPT_LEN];

    visual_target_tracking_velocity u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic logic signed [15:0] axis_speed(logic [15:0] gain, longint err,
                                                      logic [14:0] vmax);
        longint mag;
        longint v;
        mag = (err < 0) ? -err : err;
        v = (longint'(gain) * mag + 128) >> 8;
        if (v < longint'(regs.deadband))
            return '0;
        if (v > longint'(vmax))
            v = longint'(vmax);
        return (err < 0) ? 16'(-v) : 16'(v);
    endfunction

    function automatic bit update_tracker(input vtt_pkg::in_t it, output vtt_pkg::out_t cmd);
        longint ex;
        longint ey;
        cmd = '0;
        if (it.command == vtt_pkg::CMD_VISION)
        begin
            tgt_x = it.target_x;
            tgt_y = it.target_y;
            if (it.detect_code == vtt_pkg::DET_LOST)
            begin
                if (miss_run < vtt_pkg::LOST_LIMIT + 1)
                    miss_run++;
            end
            else if (it.detect_code == vtt_pkg::DET_SEEN)
            begin
                tgt_seen = 1'b1;
                miss_run = 0;
            end
            if (miss_run > vtt_pkg::LOST_LIMIT)
                tgt_seen = 1'b0;
            return 1'b0;
        end
        ex = regs.track_forward ? longint'(tgt_x) - longint'(regs.forward_offset) : 0;
        ey = longint'(tgt_y);
        cmd.action = vtt_pkg::ACT_HOLD;
        cmd.sequence_res = seq_no;
        if (tgt_seen && ex * ex + ey * ey >=
            longint'(regs.distance_threshold) * longint'(regs.distance_threshold))
        begin
            seq_no = seq_no + 16'd1;
            if (regs.track_forward)
                cmd.vel_x = axis_speed(regs.gain_x, ex, regs.max_vel_x);
            cmd.vel_y = axis_speed(regs.gain_y, ey, regs.max_vel_y);
            if (cmd.vel_x != 0 || cmd.vel_y != 0)
                cmd.action = vtt_pkg::ACT_MOVE;
        end
        return 1'b1;
    endfunction

    function automatic int gap_len(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [15:0] rand_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            case ($urandom_range(0, 3))
                0: return 16'sh8000;
                1: return 16'sh7FFF;
                2: return 16'sd0;
                default: return -16'sd1;
            endcase
        end
        if (r < 55)
            return 16'($urandom_range(0, 400)) - 16'sd200;
        return 16'($urandom);
    endfunction

    function automatic step_t vis(logic signed [15:0] x, logic signed [15:0] y,
                                  logic [1:0] code);
        step_t s;
        s = '0;
        s.it = '{vtt_pkg::CMD_VISION, x, y, code};
        return s;
    endfunction

    function automatic step_t tick();
        step_t s;
        s = '0;
        s.it.command = vtt_pkg::CMD_TICK;
        return s;
    endfunction

    function automatic step_t tick_want(logic act, logic signed [15:0] vx,
                                        logic signed [15:0] vy, logic [15:0] seq);
        step_t s;
        s = '0;
        s.it.command = vtt_pkg::CMD_TICK;
        s.typed = 1'b1;
        s.want = '{act, vx, vy, seq};
        return s;
    endfunction

    function automatic step_t set_reg(vtt_pkg::cfg_idx_t idx, logic [15:0] v);
        step_t s;
        s = '0;
        s.is_reg = 1'b1;
        s.idx = idx;
        s.data = v;
        return s;
    endfunction

    task automatic offer(input vtt_pkg::in_t it, input logic typed,
                         input vtt_pkg::out_t want);
        vtt_pkg::out_t cmd;
        int            n;
        n = gap_len(tx_calm);
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item <= it;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        if (update_tracker(it, cmd))
            due_cmds.push_back(typed ? want : cmd);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (due_cmds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input vtt_pkg::cfg_idx_t idx, input logic [15:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            vtt_pkg::REG_GAIN_X:     regs.gain_x = v;
            vtt_pkg::REG_GAIN_Y:     regs.gain_y = v;
            vtt_pkg::REG_MAX_VEL_X:  regs.max_vel_x = v[14:0];
            vtt_pkg::REG_MAX_VEL_Y:  regs.max_vel_y = v[14:0];
            vtt_pkg::REG_DEADBAND:   regs.deadband = v[14:0];
            vtt_pkg::REG_FWD_OFFSET: regs.forward_offset = v;
            vtt_pkg::REG_DIST_THR:   regs.distance_threshold = v[14:0];
            vtt_pkg::REG_TRACK_FWD:  regs.track_forward = v[0];
            default:                 ;
        endcase
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            bad_count++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("visual_target_tracking_velocity: mismatch");
        $finish;
    end

    // response side: random stalls, one long hold-off on request
    initial
    begin
        int n;
        rsp_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            n = long_hold_due ? LONG_HOLD : gap_len(rx_calm);
            long_hold_due = 1'b0;
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        vtt_pkg::out_t want;
        if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (due_cmds.size() == 0)
            begin
                $display("%0t: unexpected item action %0d vel_x %0d vel_y %0d seq %0d",
                         $time, rsp_item.action, rsp_item.vel_x, rsp_item.vel_y,
                         rsp_item.sequence_res);
                bad_count++;
            end
            else
            begin
                want = due_cmds.pop_front();
                check_field("action", 32'(want.action), 32'(rsp_item.action));
                check_field("vel_x", 32'(want.vel_x), 32'(rsp_item.vel_x));
                check_field("vel_y", 32'(want.vel_y), 32'(rsp_item.vel_y));
                check_field("sequence_res", 32'(want.sequence_res),
                            32'(rsp_item.sequence_res));
            end
        end
    end

    initial
    begin
        vtt_pkg::cfg_t c;
        vtt_pkg::in_t  it;
        int            r;
        int            burst;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_item = '0;
        cfg_wr_en = 1'b0;
        cfg_index = vtt_pkg::REG_GAIN_X;
        cfg_data = '0;
        bad_count = 0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        long_hold_due = 1'b0;
        burst = 0;
        regs = '0;
        regs.gain_x = 16'd256;
        regs.gain_y = 16'd256;
        regs.max_vel_x = 15'd128;
        regs.max_vel_y = 15'd128;
        regs.deadband = 15'd5;
        regs.forward_offset = 16'sd384;
        regs.distance_threshold = 15'd51;
        regs.track_forward = 1'b0;
        tgt_x = '0;
        tgt_y = '0;
        tgt_seen = 1'b0;
        miss_run = 0;
        seq_no = '0;

        script = '{
            tick_want(vtt_pkg::ACT_HOLD, 16'sd0, 16'sd0, 16'd0),
            vis(16'sd0, 16'sd1000, vtt_pkg::DET_SEEN),
            tick_want(vtt_pkg::ACT_MOVE, 16'sd0, 16'sd128, 16'd0),
            vis(16'sh8000, 16'sh8000, DET_KEEP),
            tick_want(vtt_pkg::ACT_MOVE, 16'sd0, -16'sd128, 16'd1),
            vis(16'sh7FFF, 16'sh7FFF, DET_ODD),
            tick_want(vtt_pkg::ACT_MOVE, 16'sd0, 16'sd128, 16'd2),
            vis(16'sd0, 16'sd3, DET_KEEP),
            tick_want(vtt_pkg::ACT_HOLD, 16'sd0, 16'sd0, 16'd3),
            vis(16'sd0, -16'sd51, vtt_pkg::DET_LOST),
            tick_want(vtt_pkg::ACT_MOVE, 16'sd0, -16'sd51, 16'd3),
            set_reg(vtt_pkg::REG_DEADBAND, 16'd100),
            set_reg(vtt_pkg::REG_DIST_THR, 16'd0),
            set_reg(vtt_pkg::REG_TRACK_FWD, 16'd1),
            vis(16'sd384, 16'sd50, DET_KEEP),
            tick_want(vtt_pkg::ACT_HOLD, 16'sd0, 16'sd0, 16'd4),
            set_reg(vtt_pkg::REG_GAIN_X, 16'hFFFF),
            set_reg(vtt_pkg::REG_MAX_VEL_X, 16'h7FFF),
            vis(16'sh8000, 16'sd0, DET_KEEP),
            tick_want(vtt_pkg::ACT_MOVE, -16'sd32767, 16'sd0, 16'd5),
            set_reg(vtt_pkg::REG_MAX_VEL_X, 16'd10),
            vis(16'sh7FFF, 16'sd0, DET_KEEP),
            tick_want(vtt_pkg::ACT_MOVE, 16'sd10, 16'sd0, 16'd6),
            vis(-16'sd300, -16'sd20000, DET_KEEP),
            tick()
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_reg)
            begin
                settle();
                write_reg(script[i].idx, script[i].data);
                cfg_wr_en <= 1'b0;
            end
            else
                offer(script[i].it, script[i].typed, script[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p % 4)
                0:
                begin
                    c.gain_x = 16'($urandom);
                    c.gain_y = 16'($urandom);
                    c.max_vel_x = 15'($urandom);
                    c.max_vel_y = 15'($urandom);
                    c.deadband = 15'($urandom);
                    c.forward_offset = 16'($urandom);
                    c.distance_threshold = 15'($urandom);
                    c.track_forward = 1'($urandom);
                end
                1:
                begin
                    c.gain_x = 16'($urandom_range(32, 1024));
                    c.gain_y = 16'($urandom_range(32, 1024));
                    c.max_vel_x = 15'($urandom_range(20, 3000));
                    c.max_vel_y = 15'($urandom_range(20, 3000));
                    c.deadband = 15'($urandom_range(0, 30));
                    c.forward_offset = 16'($urandom_range(0, 1024)) - 16'sd512;
                    c.distance_threshold = 15'($urandom_range(0, 400));
                    c.track_forward = (p < 4) ? 1'b1 : 1'($urandom);
                end
                2:
                begin
                    c.gain_x = 16'hFFFF;
                    c.gain_y = 16'hFFFF;
                    c.max_vel_x = 15'h7FFF;
                    c.max_vel_y = 15'h7FFF;
                    c.deadband = 15'h7FFF;
                    c.forward_offset = (p < 4) ? 16'sh7FFF : 16'sh8000;
                    c.distance_threshold = 15'h7FFF;
                    c.track_forward = 1'b1;
                end
                default:
                begin
                    c = '0;
                    c.forward_offset = (p < 4) ? 16'sh8000 : 16'sd0;
                    c.track_forward = (p >= 4);
                end
            endcase
            write_reg(vtt_pkg::REG_GAIN_X, c.gain_x);
            write_reg(vtt_pkg::REG_GAIN_Y, c.gain_y);
            write_reg(vtt_pkg::REG_MAX_VEL_X, {1'b0, c.max_vel_x});
            write_reg(vtt_pkg::REG_MAX_VEL_Y, {1'b0, c.max_vel_y});
            write_reg(vtt_pkg::REG_DEADBAND, {1'b0, c.deadband});
            write_reg(vtt_pkg::REG_FWD_OFFSET, c.forward_offset);
            write_reg(vtt_pkg::REG_DIST_THR, {1'b0, c.distance_threshold});
            write_reg(vtt_pkg::REG_TRACK_FWD, {15'd0, c.track_forward});
            cfg_wr_en <= 1'b0;

            // in phase 1, back-to-back items, mostly ticks, against a long receiver hold-off
            tx_calm = (p == 1);
            rx_calm = (p == 6);
            if (p == 1)
                long_hold_due = 1'b1;

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (burst > 0)
                begin
                    it.command = vtt_pkg::CMD_VISION;
                    it.detect_code = vtt_pkg::DET_LOST;
                    burst--;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 3)
                        burst = $urandom_range(18, 24);
                    it.command = (r < (tx_calm ? 75 : 40)) ? vtt_pkg::CMD_TICK
                                                           : vtt_pkg::CMD_VISION;
                    r = $urandom_range(0, 99);
                    it.detect_code = (r < 55) ? vtt_pkg::DET_SEEN :
                                     (r < 75) ? vtt_pkg::DET_LOST :
                                     (r < 90) ? DET_KEEP : DET_ODD;
                end
                it.target_x = rand_pos();
                it.target_y = rand_pos();
                offer(it, 1'b0, '0);
            end
        end

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        settle();
        repeat (8) @(posedge clk);
        if (bad_count == 0)
            $display("visual_target_tracking_velocity: match");
        else
            $display("visual_target_tracking_velocity: mismatch");
        $finish;
    end

endmodule
